// ===== sv/nfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// nfrc_pkg: shared types and constants for the floor ray cast unit
// Field widths, payload structs, sequencer states and arithmetic unit control.
// ----------------------------------------------------------------------------
package nfrc_pkg;

  localparam int COORD_W   = 24;
  localparam int EXT_W     = COORD_W + 1;
  localparam int DIST_W    = COORD_W - 1;
  localparam int ACC_W     = 3 * COORD_W + 4;
  localparam int CNT_W     = $clog2(COORD_W + 1);
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd3;

  // multiply-accumulate steps
  localparam logic [OP_W-1:0] OP_DET_P = 4'd0;
  localparam logic [OP_W-1:0] OP_DET_M = 4'd1;
  localparam logic [OP_W-1:0] OP_U_P   = 4'd2;
  localparam logic [OP_W-1:0] OP_U_M   = 4'd3;
  localparam logic [OP_W-1:0] OP_V_P   = 4'd4;
  localparam logic [OP_W-1:0] OP_V_M   = 4'd5;
  localparam logic [OP_W-1:0] OP_T_P   = 4'd6;
  localparam logic [OP_W-1:0] OP_T_M1  = 4'd7;
  localparam logic [OP_W-1:0] OP_T_M2  = 4'd8;
  localparam logic [OP_W-1:0] OP_LIM   = 4'd9;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
    logic                      last_triangle;
  } nfrc_in_t;

  typedef struct packed {
    logic                      found;
    logic signed [COORD_W-1:0] hit_height;
    logic [DIST_W-1:0]         hit_distance;
  } nfrc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_CHK1, ST_CHK2, ST_DIV, ST_UPD, ST_OUT
  } nfrc_state_t;

  typedef struct packed {
    logic mul_start;
    logic div_start;
    logic clr;
    logic neg;
  } nfrc_arith_ctl_t;

  typedef struct packed {
    logic busy;
  } nfrc_arith_sts_t;

endpackage

// ===== sv/nearest_floor_ray_cast_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_floor_ray_cast_unit: downward ray cast against a triangle stream
// Fixed-point Moller-Trumbore test per triangle, keeps the nearest hit and
// reports it on the beat marked last.
//
//   channel | ports                          | beat
//   in      | in_valid, in_stall, in_data    | one triangle
//   out     | out_valid, out_stall, out_data | one result per query
//   cfg     | cfg_we, cfg_index, cfg_data    | one register write
//
// Each triangle runs ten multiply-accumulate passes (load, shift-add steps,
// handoff) and a division through the one shared adder in nfrc_arith, plus
// the accept, two check and one update step. A zero determinant or an early
// reject ends the work early. A last triangle adds a result state that holds
// while out_stall is high. in_stall is high in every state but idle. Reset is
// synchronous; it clears the query state and the origin registers and sets
// the maximum distance to its default.
// ----------------------------------------------------------------------------
module nearest_floor_ray_cast_unit
  import nfrc_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  nfrc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output nfrc_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data
);

  nfrc_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] org_x_r, org_y_r, org_z_r;
  logic [DIST_W-1:0]         max_r;
  logic [COORD_W-1:0]        best_r, best_nxt;
  logic                      seen_r, seen_nxt;
  logic [OP_W-1:0]           op_r;

  logic signed [EXT_W-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r, tx_r, ty_r, tz_r;
  logic                    last_r, sgn_r;
  logic signed [ACC_W-1:0] det_r, un_r, vn_r, tn_r, uv_r;
  logic [DIST_W-1:0]       cand_r;
  nfrc_out_t               out_r, out_nxt;

  nfrc_arith_ctl_t         ctl;
  nfrc_arith_sts_t         sts;
  logic signed [ACC_W-1:0] acc, op_a;
  logic signed [EXT_W-1:0] op_b, maxp1;
  logic [DIST_W-1:0]       quo;
  logic                    rej1, rej2, better;
  logic signed [EXT_W-1:0] h;

  nfrc_arith u_arith (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .op_a (op_a),
    .op_b (op_b),
    .op_d (tn_r),
    .acc  (acc),
    .quo  (quo),
    .sts  (sts)
  );

  assign maxp1 = EXT_W'(max_r) + EXT_W'(1);
  assign rej1  = un_r[ACC_W-1] | vn_r[ACC_W-1] | (det_r < un_r) | tn_r[ACC_W-1] |
                 (tn_r == '0);
  assign rej2  = (det_r < uv_r) | (tn_r >= acc);

  // operand select per step
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    ctl.clr = 1'b0;
    ctl.neg = 1'b0;
    ctl.mul_start = (state_r == ST_LOAD);
    ctl.div_start = (state_r == ST_CHK2) && !rej2;
    case (op_r)
      OP_DET_P: begin op_a = ACC_W'(e1z_r); op_b = e2x_r; ctl.clr = 1'b1; end
      OP_DET_M: begin op_a = ACC_W'(e1x_r); op_b = e2z_r; ctl.neg = 1'b1; end
      OP_U_P:   begin op_a = ACC_W'(tz_r); op_b = e2x_r; ctl.clr = 1'b1; ctl.neg = sgn_r; end
      OP_U_M:   begin op_a = ACC_W'(tx_r); op_b = e2z_r; ctl.neg = ~sgn_r; end
      OP_V_P:   begin op_a = ACC_W'(tx_r); op_b = e1z_r; ctl.clr = 1'b1; ctl.neg = sgn_r; end
      OP_V_M:   begin op_a = ACC_W'(tz_r); op_b = e1x_r; ctl.neg = ~sgn_r; end
      OP_T_P:   begin op_a = det_r; op_b = ty_r; ctl.clr = 1'b1; end
      OP_T_M1:  begin op_a = un_r; op_b = e1y_r; ctl.neg = 1'b1; end
      OP_T_M2:  begin op_a = vn_r; op_b = e2y_r; ctl.neg = 1'b1; end
      OP_LIM:   begin op_a = det_r; op_b = maxp1; ctl.clr = 1'b1; end
      // divisor for the distance division
      default:  begin op_a = det_r; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_MUL;
      ST_MUL: begin
        if (!sts.busy) begin
          if (op_r == OP_DET_M && acc == '0) state_nxt = ST_UPD;
          else if (op_r == OP_LIM)           state_nxt = ST_CHK1;
          else                               state_nxt = ST_LOAD;
        end
      end
      ST_CHK1: state_nxt = rej1 ? ST_UPD : ST_CHK2;
      ST_CHK2: state_nxt = rej2 ? ST_UPD : ST_DIV;
      ST_DIV:  if (!sts.busy) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = last_r ? ST_OUT : ST_IDLE;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
  end

  // best-hit update and result
  always_comb begin
    better   = (cand_r != '0) && ({1'b0, cand_r} < best_r);
    best_nxt = better ? {1'b0, cand_r} : best_r;
    seen_nxt = seen_r | better;
    h        = EXT_W'(org_y_r) - $signed({2'b00, best_nxt[DIST_W-1:0]});
    out_nxt.found = seen_nxt;
    if (!seen_nxt) begin
      out_nxt.hit_height   = '0;
      out_nxt.hit_distance = '0;
    end else begin
      out_nxt.hit_height   = (h[EXT_W-1] != h[COORD_W-1]) ?
                             {1'b1, {(COORD_W-1){1'b0}}} : h[COORD_W-1:0];
      out_nxt.hit_distance = best_nxt[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= '0;
      best_r  <= '1;
      seen_r  <= 1'b0;
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      max_r   <= DIST_W'(4096 << FRACTION_BITS);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ORIGIN_X: org_x_r <= cfg_data;
          CFG_ORIGIN_Y: org_y_r <= cfg_data;
          CFG_ORIGIN_Z: org_z_r <= cfg_data;
          CFG_MAX_DIST: max_r   <= cfg_data[DIST_W-1:0];
          default:      max_r   <= max_r;
        endcase
      end
      if (state_r == ST_IDLE) begin
        op_r <= '0;
      end else if (state_r == ST_MUL && !sts.busy) begin
        op_r <= op_r + OP_W'(1);
      end
      if (state_r == ST_UPD) begin
        if (last_r) begin
          best_r <= '1;
          seen_r <= 1'b0;
        end else begin
          best_r <= best_nxt;
          seen_r <= seen_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      e1x_r  <= EXT_W'(in_data.b_x) - EXT_W'(in_data.a_x);
      e1y_r  <= EXT_W'(in_data.b_y) - EXT_W'(in_data.a_y);
      e1z_r  <= EXT_W'(in_data.b_z) - EXT_W'(in_data.a_z);
      e2x_r  <= EXT_W'(in_data.c_x) - EXT_W'(in_data.a_x);
      e2y_r  <= EXT_W'(in_data.c_y) - EXT_W'(in_data.a_y);
      e2z_r  <= EXT_W'(in_data.c_z) - EXT_W'(in_data.a_z);
      tx_r   <= EXT_W'(org_x_r) - EXT_W'(in_data.a_x);
      ty_r   <= EXT_W'(org_y_r) - EXT_W'(in_data.a_y);
      tz_r   <= EXT_W'(org_z_r) - EXT_W'(in_data.a_z);
      last_r <= in_data.last_triangle;
    end
    if (state_r == ST_MUL && !sts.busy) begin
      case (op_r)
        OP_DET_M: begin
          det_r  <= acc[ACC_W-1] ? -acc : acc;
          sgn_r  <= acc[ACC_W-1];
          cand_r <= '0;
        end
        OP_U_M:  un_r <= acc;
        OP_V_M:  vn_r <= acc;
        OP_T_M2: tn_r <= acc;
        default: cand_r <= cand_r;
      endcase
    end
    if (state_r == ST_CHK1) begin
      uv_r <= un_r + vn_r;
    end
    if (state_r == ST_DIV && !sts.busy) begin
      cand_r <= quo;
    end
    if (state_r == ST_UPD) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  a_busy_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> (state_r == ST_MUL || state_r == ST_DIV))
    else $error("arith unit busy outside a work state");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.hit_height == '0 &&
                                        out_data.hit_distance == '0))
    else $error("no-hit result with nonzero fields");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |-> (out_data.hit_distance != '0))
    else $error("hit with zero distance");

  a_query_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> (!seen_r && best_r == '1))
    else $error("query state not cleared after result beat");

  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> !best_r[COORD_W-1])
    else $error("best distance out of range");
`endif

endmodule

// ===== sv/nfrc_arith.sv =====
// ----------------------------------------------------------------------------
// nfrc_arith: shared shift-add arithmetic unit
// One wide adder serves radix-2 signed multiply-accumulate and restoring
// division, one bit per cycle.
// ----------------------------------------------------------------------------
module nfrc_arith
  import nfrc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  nfrc_arith_ctl_t          ctl,
  input  logic signed [ACC_W-1:0]  op_a,
  input  logic signed [EXT_W-1:0]  op_b,
  input  logic signed [ACC_W-1:0]  op_d,
  output logic signed [ACC_W-1:0]  acc,
  output logic [DIST_W-1:0]        quo,
  output nfrc_arith_sts_t          sts
);

  logic signed [ACC_W-1:0] acc_r, m_r, addend, sum;
  logic signed [EXT_W-1:0] b_r;
  logic [DIST_W-1:0]       q_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    busy_r, div_r, neg_r;
  logic                    top_bit, sub, last_step, keep;

  always_comb begin
    top_bit   = (cnt_r == CNT_W'(COORD_W));
    last_step = div_r ? (cnt_r == CNT_W'(COORD_W - 2)) : top_bit;
    sub       = div_r | (neg_r ^ top_bit);
    addend    = (div_r | b_r[0]) ? m_r : '0;
    sum       = acc_r + (sub ? ~addend : addend) + ACC_W'(sub);
    keep      = ~sum[ACC_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.mul_start || ctl.div_start) begin
      busy_r <= 1'b1;
    end else if (busy_r && last_step) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_start) begin
      m_r   <= op_a;
      b_r   <= op_b;
      cnt_r <= '0;
      div_r <= 1'b0;
      neg_r <= ctl.neg;
      if (ctl.clr) begin
        acc_r <= '0;
      end
    end else if (ctl.div_start) begin
      acc_r <= op_d;
      m_r   <= op_a <<< (COORD_W - 2);
      q_r   <= '0;
      cnt_r <= '0;
      div_r <= 1'b1;
      neg_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      b_r   <= b_r >>> 1;
      if (div_r) begin
        if (keep) begin
          acc_r <= sum;
        end
        q_r <= {q_r[DIST_W-2:0], keep};
        m_r <= m_r >>> 1;
      end else begin
        acc_r <= sum;
        m_r   <= m_r <<< 1;
      end
    end
  end

  assign acc      = acc_r;
  assign quo      = q_r;
  assign sts.busy = busy_r;

endmodule
